/* rtl/pcc_pkg.sv */
// shared types and constants of the pearson correlation engine
package pcc_pkg;

   localparam int MAX_POINTS  = 4096;
   localparam int SAMPLE_BITS = 24;
   localparam int SAMPLE_W    = 24;
   localparam int CNT_W       = 13;
   localparam int SX_W        = 36;
   localparam int SXY_W       = 60;
   localparam int SQ_W        = 59;
   localparam int XX_W        = 2 * SAMPLE_BITS - 1;
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int FLOOR_W     = 41;
   localparam int CORR_W      = 16;
   localparam int MIN_POINTS  = 3;
   localparam int V_W         = 76;
   localparam int P_W         = 142;
   localparam int PW          = 176;
   localparam int MW          = 88;
   localparam int K_W         = 16;
   localparam int K_MAX       = 32768;
   localparam int FRAC_W      = 16;
   localparam int QDEPTH      = 2;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);
   localparam int QPTR_W      = $clog2(QDEPTH);

   localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1);
   localparam logic [CORR_W-1:0]  CORR_MAX    = CORR_W'(32767);

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SX_W-1:0]  sum_x;
      logic signed [SX_W-1:0]  sum_y;
      logic signed [SXY_W-1:0] sum_xy;
      logic [SQ_W-1:0]         sum_xx;
      logic [SQ_W-1:0]         sum_yy;
      logic                    dropped;
   } snap_type;

   typedef struct packed {
      logic          start;
      logic [PW-1:0] mcand;
      logic [MW-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic          done;
      logic [PW-1:0] product;
   } mul_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_MUL, ST_SQ, ST_PROBE, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      PH_NXY, PH_SXSY, PH_NXX, PH_SXSX, PH_NYY, PH_SYSY, PH_PROD, PH_LHS, PH_SEARCH
   } phase_type;

endpackage

/* rtl/pcc_req_if.sv */
// sample pair channel
interface pcc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pcc_pkg::SAMPLE_W-1:0]  x_sample;
   logic signed [pcc_pkg::SAMPLE_W-1:0]  y_sample;
   logic                                 last;
   modport source (output valid, x_sample, y_sample, last, input ready);
   modport sink (input valid, x_sample, y_sample, last, output ready);
endinterface

/* rtl/pcc_rsp_if.sv */
// correlation result channel
interface pcc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pcc_pkg::CORR_W-1:0]  correlation;
   logic                               defined;
   logic [pcc_pkg::CNT_W-1:0]          point_count;
   logic                               overflowed;
   modport source (output valid, correlation, defined, point_count, overflowed, input ready);
   modport sink (input valid, correlation, defined, point_count, overflowed, output ready);
endinterface

/* rtl/pcc_csr_if.sv */
// variance floor write channel
interface pcc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pcc_pkg::FLOOR_W-1:0]   variance_floor;
   modport source (output valid, variance_floor, input ready);
   modport sink (input valid, variance_floor, output ready);
endinterface

/* rtl/pcc_front.sv */
// front end: takes sample pairs and keeps the running sums of a series
module pcc_front (
   input  logic                        clock,
   input  logic                        reset,
   pcc_req_if.sink                     req_bus,
   input  logic [pcc_pkg::QCNT_W-1:0]  q_count,
   output logic                        q_push,
   output pcc_pkg::snap_type           q_data
);

   logic                                  accept;
   logic [pcc_pkg::QCNT_W:0]              pend;
   logic signed [pcc_pkg::SAMPLE_BITS-1:0] xs;
   logic signed [pcc_pkg::SAMPLE_BITS-1:0] ys;
   logic signed [pcc_pkg::PROD_W-1:0]     xy_full;
   logic signed [pcc_pkg::PROD_W-1:0]     xx_full;
   logic signed [pcc_pkg::PROD_W-1:0]     yy_full;

   logic                                  a_valid_ff;
   logic                                  a_last_ff;
   logic signed [pcc_pkg::SAMPLE_BITS-1:0] a_x_ff;
   logic signed [pcc_pkg::SAMPLE_BITS-1:0] a_y_ff;
   logic signed [pcc_pkg::PROD_W-1:0]     a_xy_ff;
   logic [pcc_pkg::XX_W-1:0]              a_xx_ff;
   logic [pcc_pkg::XX_W-1:0]              a_yy_ff;

   pcc_pkg::snap_type                     acc_ff;
   pcc_pkg::snap_type                     acc_in;
   pcc_pkg::snap_type                     nx;

   // room is kept for a last word already in the product stage
   assign pend = {1'b0, q_count} + {{pcc_pkg::QCNT_W{1'b0}}, a_valid_ff & a_last_ff};
   assign req_bus.ready = pend < (pcc_pkg::QCNT_W + 1)'(pcc_pkg::QDEPTH);
   assign accept = req_bus.valid & req_bus.ready;

   assign xs = req_bus.x_sample[pcc_pkg::SAMPLE_BITS-1:0];
   assign ys = req_bus.y_sample[pcc_pkg::SAMPLE_BITS-1:0];
   assign xy_full = xs * ys;
   assign xx_full = xs * xs;
   assign yy_full = ys * ys;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_last_ff <= req_bus.last;
      a_x_ff    <= xs;
      a_y_ff    <= ys;
      a_xy_ff   <= xy_full;
      a_xx_ff   <= xx_full[pcc_pkg::XX_W-1:0];
      a_yy_ff   <= yy_full[pcc_pkg::XX_W-1:0];
   end

   always_comb begin
      nx = acc_ff;
      if (acc_ff.count < pcc_pkg::CNT_W'(pcc_pkg::MAX_POINTS)) begin
         nx.count  = acc_ff.count + pcc_pkg::CNT_W'(1);
         nx.sum_x  = acc_ff.sum_x + pcc_pkg::SX_W'(a_x_ff);
         nx.sum_y  = acc_ff.sum_y + pcc_pkg::SX_W'(a_y_ff);
         nx.sum_xy = acc_ff.sum_xy + pcc_pkg::SXY_W'(a_xy_ff);
         nx.sum_xx = acc_ff.sum_xx + pcc_pkg::SQ_W'(a_xx_ff);
         nx.sum_yy = acc_ff.sum_yy + pcc_pkg::SQ_W'(a_yy_ff);
      end else begin
         nx.dropped = 1'b1;
      end
      acc_in = acc_ff;
      q_push = 1'b0;
      if (a_valid_ff) begin
         if (a_last_ff) begin
            q_push = 1'b1;
            acc_in = '0;
         end else begin
            acc_in = nx;
         end
      end
   end

   assign q_data = nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* rtl/pcc_fifo.sv */
// short queue of finished series sums between front and back
module pcc_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  pcc_pkg::snap_type           push_data,
   input  logic                        pop,
   output pcc_pkg::snap_type           head,
   output logic [pcc_pkg::QCNT_W-1:0]  count
);

   pcc_pkg::snap_type                  mem_ff [pcc_pkg::QDEPTH];
   logic [pcc_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [pcc_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [pcc_pkg::QCNT_W-1:0]         count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + pcc_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + pcc_pkg::QPTR_W'(1);
         end
         count_ff <= count_ff + pcc_pkg::QCNT_W'(push) - pcc_pkg::QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

/* rtl/pcc_mul.sv */
// shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero
module pcc_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  pcc_pkg::mul_req_type  mul_req,
   output pcc_pkg::mul_rsp_type  mul_rsp
);

   logic                     busy_ff;
   logic                     done_ff;
   logic [pcc_pkg::PW-1:0]   acc_ff;
   logic [pcc_pkg::PW-1:0]   mc_ff;
   logic [pcc_pkg::MW-1:0]   mp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && mp_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         acc_ff <= '0;
         mc_ff  <= mul_req.mcand;
         mp_ff  <= mul_req.mplier;
      end else if (busy_ff && mp_ff != '0) begin
         if (mp_ff[0]) begin
            acc_ff <= acc_ff + mc_ff;
         end
         mc_ff <= {mc_ff[pcc_pkg::PW-2:0], 1'b0};
         mp_ff <= {1'b0, mp_ff[pcc_pkg::MW-1:1]};
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

/* rtl/pcc_back.sv */
// back end: centered sums, validity test and rounded coefficient search
module pcc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pcc_pkg::FLOOR_W-1:0]  variance_floor,
   input  logic [pcc_pkg::QCNT_W-1:0]   q_count,
   input  pcc_pkg::snap_type            q_head,
   output logic                         q_pop,
   output pcc_pkg::mul_req_type         mul_req,
   input  pcc_pkg::mul_rsp_type         mul_rsp,
   pcc_rsp_if.source                    rsp_bus
);

   pcc_pkg::state_type                 state_ff, state_in;
   pcc_pkg::phase_type                 phase_ff, phase_in;
   pcc_pkg::snap_type                  snap_ff, snap_in;
   logic signed [pcc_pkg::V_W-1:0]     tmp_ff, tmp_in;
   logic signed [pcc_pkg::V_W-1:0]     sxy_ff, sxy_in;
   logic signed [pcc_pkg::V_W-1:0]     sxx_ff, sxx_in;
   logic [pcc_pkg::P_W-1:0]            p_ff, p_in;
   logic [pcc_pkg::PW-1:0]             l_ff, l_in;
   logic [pcc_pkg::K_W-1:0]            lo_ff, lo_in;
   logic [pcc_pkg::K_W-1:0]            hi_ff, hi_in;
   logic [pcc_pkg::K_W-1:0]            mid_ff, mid_in;
   logic [2*pcc_pkg::K_W-1:0]          odd2_ff, odd2_in;
   logic                               neg_ff, neg_in;
   logic                               def_ff, def_in;
   logic [pcc_pkg::CORR_W-1:0]         corr_ff, corr_in;

   logic                               rsp_valid_ff;
   logic [pcc_pkg::CORR_W-1:0]         rsp_corr_ff;
   logic                               rsp_def_ff;
   logic [pcc_pkg::CNT_W-1:0]          rsp_count_ff;
   logic                               rsp_ovf_ff;
   logic                               rsp_load;

   logic signed [pcc_pkg::V_W-1:0]     prod_v;
   logic signed [pcc_pkg::V_W-1:0]     syy_v;
   logic [pcc_pkg::SX_W-1:0]           ax;
   logic [pcc_pkg::SX_W-1:0]           ay;
   logic [pcc_pkg::SXY_W-1:0]          axy;
   logic [pcc_pkg::V_W-1:0]            sxy_abs;
   logic                               m2_neg;
   logic                               def_v;
   logic [pcc_pkg::K_W:0]              mid_sum;
   logic [pcc_pkg::K_W:0]              odd_wide;
   logic [pcc_pkg::K_W-1:0]            odd;
   logic [pcc_pkg::K_W-1:0]            lo_n;
   logic [pcc_pkg::K_W-1:0]            hi_n;

   assign prod_v  = pcc_pkg::V_W'(mul_rsp.product);
   assign ax      = snap_ff.sum_x[pcc_pkg::SX_W-1] ? unsigned'(-snap_ff.sum_x)
                                                   : unsigned'(snap_ff.sum_x);
   assign ay      = snap_ff.sum_y[pcc_pkg::SX_W-1] ? unsigned'(-snap_ff.sum_y)
                                                   : unsigned'(snap_ff.sum_y);
   assign axy     = snap_ff.sum_xy[pcc_pkg::SXY_W-1] ? unsigned'(-snap_ff.sum_xy)
                                                     : unsigned'(snap_ff.sum_xy);
   assign sxy_abs = sxy_ff[pcc_pkg::V_W-1] ? unsigned'(-sxy_ff) : unsigned'(sxy_ff);
   assign m2_neg  = snap_ff.sum_x[pcc_pkg::SX_W-1] ^ snap_ff.sum_y[pcc_pkg::SX_W-1];
   assign syy_v   = tmp_ff - prod_v;
   assign def_v   = (sxx_ff != '0) && (syy_v != '0) &&
                    (unsigned'(sxx_ff) >= pcc_pkg::V_W'(variance_floor)) &&
                    (unsigned'(syy_v) >= pcc_pkg::V_W'(variance_floor));

   // bisection point and its odd value 2*mid-1
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} + (pcc_pkg::K_W + 1)'(1);
   assign odd_wide = {mid_sum[pcc_pkg::K_W:1], 1'b0} - (pcc_pkg::K_W + 1)'(1);
   assign odd      = odd_wide[pcc_pkg::K_W-1:0];

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      snap_in  = snap_ff;
      tmp_in   = tmp_ff;
      sxy_in   = sxy_ff;
      sxx_in   = sxx_ff;
      p_in     = p_ff;
      l_in     = l_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      odd2_in  = odd2_ff;
      neg_in   = neg_ff;
      def_in   = def_ff;
      corr_in  = corr_ff;
      q_pop    = 1'b0;
      rsp_load = 1'b0;
      mul_req.start  = 1'b0;
      mul_req.mcand  = '0;
      mul_req.mplier = '0;
      lo_n = lo_ff;
      hi_n = hi_ff;
      case (state_ff)
         pcc_pkg::ST_IDLE: begin
            if (q_count != '0) begin
               q_pop    = 1'b1;
               snap_in  = q_head;
               state_in = pcc_pkg::ST_START;
            end
         end
         pcc_pkg::ST_START: begin
            if (snap_ff.count < pcc_pkg::CNT_W'(pcc_pkg::MIN_POINTS)) begin
               def_in   = 1'b0;
               corr_in  = '0;
               state_in = pcc_pkg::ST_EMIT;
            end else begin
               mul_req.start  = 1'b1;
               mul_req.mcand  = pcc_pkg::PW'(axy);
               mul_req.mplier = pcc_pkg::MW'(snap_ff.count);
               phase_in = pcc_pkg::PH_NXY;
               state_in = pcc_pkg::ST_MUL;
            end
         end
         pcc_pkg::ST_MUL: begin
            if (mul_rsp.done) begin
               case (phase_ff)
                  pcc_pkg::PH_NXY: begin
                     tmp_in = snap_ff.sum_xy[pcc_pkg::SXY_W-1] ? -prod_v : prod_v;
                     mul_req.start  = 1'b1;
                     mul_req.mcand  = pcc_pkg::PW'(ax);
                     mul_req.mplier = pcc_pkg::MW'(ay);
                     phase_in = pcc_pkg::PH_SXSY;
                  end
                  pcc_pkg::PH_SXSY: begin
                     sxy_in = m2_neg ? tmp_ff + prod_v : tmp_ff - prod_v;
                     mul_req.start  = 1'b1;
                     mul_req.mcand  = pcc_pkg::PW'(snap_ff.sum_xx);
                     mul_req.mplier = pcc_pkg::MW'(snap_ff.count);
                     phase_in = pcc_pkg::PH_NXX;
                  end
                  pcc_pkg::PH_NXX: begin
                     tmp_in = prod_v;
                     mul_req.start  = 1'b1;
                     mul_req.mcand  = pcc_pkg::PW'(ax);
                     mul_req.mplier = pcc_pkg::MW'(ax);
                     phase_in = pcc_pkg::PH_SXSX;
                  end
                  pcc_pkg::PH_SXSX: begin
                     sxx_in = tmp_ff - prod_v;
                     mul_req.start  = 1'b1;
                     mul_req.mcand  = pcc_pkg::PW'(snap_ff.sum_yy);
                     mul_req.mplier = pcc_pkg::MW'(snap_ff.count);
                     phase_in = pcc_pkg::PH_NYY;
                  end
                  pcc_pkg::PH_NYY: begin
                     tmp_in = prod_v;
                     mul_req.start  = 1'b1;
                     mul_req.mcand  = pcc_pkg::PW'(ay);
                     mul_req.mplier = pcc_pkg::MW'(ay);
                     phase_in = pcc_pkg::PH_SYSY;
                  end
                  pcc_pkg::PH_SYSY: begin
                     neg_in = sxy_ff[pcc_pkg::V_W-1];
                     def_in = def_v;
                     if (!def_v) begin
                        corr_in  = '0;
                        state_in = pcc_pkg::ST_EMIT;
                     end else begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = pcc_pkg::PW'(unsigned'(sxx_ff));
                        mul_req.mplier = pcc_pkg::MW'(unsigned'(syy_v));
                        phase_in = pcc_pkg::PH_PROD;
                     end
                  end
                  pcc_pkg::PH_PROD: begin
                     p_in = mul_rsp.product[pcc_pkg::P_W-1:0];
                     mul_req.start  = 1'b1;
                     mul_req.mcand  = pcc_pkg::PW'({sxy_abs, {pcc_pkg::FRAC_W{1'b0}}});
                     mul_req.mplier = pcc_pkg::MW'({sxy_abs, {pcc_pkg::FRAC_W{1'b0}}});
                     phase_in = pcc_pkg::PH_LHS;
                  end
                  pcc_pkg::PH_LHS: begin
                     l_in     = mul_rsp.product;
                     lo_in    = '0;
                     hi_in    = pcc_pkg::K_W'(pcc_pkg::K_MAX);
                     phase_in = pcc_pkg::PH_SEARCH;
                     state_in = pcc_pkg::ST_SQ;
                  end
                  pcc_pkg::PH_SEARCH: begin
                     // keep mid when (2mid-1)^2 * Sxx*Syy still fits under the scaled Sxy^2
                     if (l_ff >= mul_rsp.product) begin
                        lo_n = mid_ff;
                     end else begin
                        hi_n = mid_ff - pcc_pkg::K_W'(1);
                     end
                     lo_in = lo_n;
                     hi_in = hi_n;
                     if (lo_n < hi_n) begin
                        state_in = pcc_pkg::ST_SQ;
                     end else begin
                        if (neg_ff) begin
                           corr_in = pcc_pkg::CORR_W'(-signed'({1'b0, lo_n}));
                        end else if (lo_n[pcc_pkg::K_W-1]) begin
                           corr_in = pcc_pkg::CORR_MAX;
                        end else begin
                           corr_in = pcc_pkg::CORR_W'(lo_n);
                        end
                        state_in = pcc_pkg::ST_EMIT;
                     end
                  end
                  default: begin
                     state_in = pcc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         pcc_pkg::ST_SQ: begin
            mid_in   = mid_sum[pcc_pkg::K_W:1];
            odd2_in  = odd * odd;
            state_in = pcc_pkg::ST_PROBE;
         end
         pcc_pkg::ST_PROBE: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = pcc_pkg::PW'(p_ff);
            mul_req.mplier = pcc_pkg::MW'(odd2_ff);
            state_in = pcc_pkg::ST_MUL;
         end
         pcc_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = pcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcc_pkg::ST_IDLE;
         phase_ff     <= pcc_pkg::PH_NXY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      tmp_ff  <= tmp_in;
      sxy_ff  <= sxy_in;
      sxx_ff  <= sxx_in;
      p_ff    <= p_in;
      l_ff    <= l_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      odd2_ff <= odd2_in;
      neg_ff  <= neg_in;
      def_ff  <= def_in;
      corr_ff <= corr_in;
      if (rsp_load) begin
         rsp_corr_ff  <= corr_ff;
         rsp_def_ff   <= def_ff;
         rsp_count_ff <= snap_ff.count;
         rsp_ovf_ff   <= snap_ff.dropped;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.correlation = rsp_corr_ff;
   assign rsp_bus.defined     = rsp_def_ff;
   assign rsp_bus.point_count = rsp_count_ff;
   assign rsp_bus.overflowed  = rsp_ovf_ff;

endmodule

/* rtl/pearson_correlation_engine_core.sv */
// Pearson correlation engine, top level
//
// req_bus carries one sample pair per word (x_sample, y_sample, last); a word
// with last set closes a series. For each series one word leaves on rsp_bus:
// the coefficient in Q1.15, the defined flag, the pair count and the dropped
// pairs flag. csr_bus writes the variance floor; it is always ready.
// Pairs are taken one per cycle while req_bus is ready; two register stages
// form products and sums, and a closed series is parked in a two-entry queue
// for the back end. The back end spends its time in one shift-add multiplier
// that retires one multiplier bit per cycle: six centered-sum products,
// Sxx*Syy and the scaled Sxy square, then a bisection with one product per
// step. A series under 3 pairs skips the products and yields an undefined
// result.
// req_bus ready drops while the queue is full: two closed series waiting, or
// one waiting and a closing word still in the product stage.
// A stalled rsp_bus holds its word; the back end waits only when a new result
// is done and the output register is still full.
// Reset clears the sums, the queue and the output valid, and sets the floor to 1.
module pearson_correlation_engine_core (
   input logic        clock,
   input logic        reset,
   pcc_req_if.sink    req_bus,
   pcc_rsp_if.source  rsp_bus,
   pcc_csr_if.sink    csr_bus
);

   logic [pcc_pkg::FLOOR_W-1:0]  floor_ff;
   logic                         q_push;
   logic                         q_pop;
   pcc_pkg::snap_type            q_data;
   pcc_pkg::snap_type            q_head;
   logic [pcc_pkg::QCNT_W-1:0]   q_count;
   pcc_pkg::mul_req_type         mul_req;
   pcc_pkg::mul_rsp_type         mul_rsp;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= pcc_pkg::FLOOR_RESET;
      end else if (csr_bus.valid) begin
         floor_ff <= csr_bus.variance_floor;
      end
   end

   pcc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_count (q_count),
      .q_push  (q_push),
      .q_data  (q_data)
   );

   pcc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .count     (q_count)
   );

   pcc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   pcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .variance_floor (floor_ff),
      .q_count        (q_count),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .mul_req        (mul_req),
      .mul_rsp        (mul_rsp),
      .rsp_bus        (rsp_bus)
   );

endmodule

/* rtl/pcc_checker.sv */
// port-level checks of the correlation engine, bound to the top level
module pcc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pcc_pkg::CORR_W-1:0]   rsp_correlation,
   input logic                         rsp_defined,
   input logic [pcc_pkg::CNT_W-1:0]    rsp_point_count,
   input logic                         rsp_overflowed
);

   // a stalled result word keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_correlation) &&
      $stable(rsp_defined) && $stable(rsp_point_count) && $stable(rsp_overflowed))
      else $error("result word changed while stalled");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_defined |-> rsp_correlation == '0)
      else $error("undefined result with nonzero correlation");

   a_def_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_defined |-> rsp_point_count >= pcc_pkg::CNT_W'(pcc_pkg::MIN_POINTS))
      else $error("defined result with too few pairs");

   // dropping only starts once the series is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_point_count == pcc_pkg::CNT_W'(pcc_pkg::MAX_POINTS))
      else $error("dropped pairs below capacity");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind pearson_correlation_engine_core pcc_checker u_pcc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_correlation (rsp_bus.correlation),
   .rsp_defined     (rsp_bus.defined),
   .rsp_point_count (rsp_bus.point_count),
   .rsp_overflowed  (rsp_bus.overflowed)
);
